>>> rtl/core/phx_pkg.sv
// Philox4x32 generator shared types and constants.
package phx_pkg;
	localparam logic [31:0] MUL0 = 32'hD2511F53;
	localparam logic [31:0] MUL1 = 32'hCD9E8D57;
	localparam logic [31:0] WEYL0 = 32'h9E3779B9;
	localparam logic [31:0] WEYL1 = 32'hBB67AE85;
	localparam int unsigned ROUNDS = 10;

	typedef struct packed {
		logic [31:0] c0;
		logic [31:0] c1;
		logic [31:0] c2;
		logic [31:0] c3;
		logic [31:0] k0;
		logic [31:0] k1;
	} blk_t;
endpackage

>>> rtl/core/phx_if.sv
// Valid/ready channel interfaces for the generator.
interface phx_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] subsequence;
	modport source(output valid, output subsequence, input ready);
	modport sink(input valid, input subsequence, output ready);
endinterface

interface phx_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_word;
	logic [31:0] uniform_bits;
	modport source(output valid, output random_word, output uniform_bits, input ready);
	modport sink(input valid, input random_word, input uniform_bits, output ready);
endinterface

>>> rtl/core/philox4x32_uniform_generator_unit.sv
// Top level of the Philox4x32-10 uniform generator.
// Accepts one subsequence per cycle while the output is not stalled, and
// returns its first Philox word and a single-precision uniform in (0,1].
// The chain has ten round cells of two stages each (multiply, then mix) and
// two conversion stages. The whole chain advances together and holds when
// the output is stalled; the seed is sampled as an item enters.
module philox4x32_uniform_generator_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          seed_we,
	input  logic [63:0]   seed_wdata,
	phx_in_if.sink        in_ch,
	phx_out_if.source     out_ch
);
	logic [63:0]   seed_q;
	logic          en;
	logic          vld [0:phx_pkg::ROUNDS];
	phx_pkg::blk_t blk [0:phx_pkg::ROUNDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seed_q <= '0;
		else if (seed_we) seed_q <= seed_wdata;
	end

	assign en = out_ch.ready || !out_ch.valid;
	assign in_ch.ready = en;
	assign vld[0] = in_ch.valid;
	assign blk[0] = '{c0: 32'd0, c1: 32'd0, c2: in_ch.subsequence[31:0],
		c3: in_ch.subsequence[63:32], k0: seed_q[31:0], k1: seed_q[63:32]};

	for (genvar g = 0; g < phx_pkg::ROUNDS; g++) begin : g_rnd
		phx_round_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vld[g]), .blk_in(blk[g]),
			.vld_out(vld[g+1]), .blk_out(blk[g+1])
		);
	end

	phx_uniform_cell u_unif (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld[phx_pkg::ROUNDS]), .word_in(blk[phx_pkg::ROUNDS].c0),
		.vld_out(out_ch.valid), .word_out(out_ch.random_word),
		.bits_out(out_ch.uniform_bits)
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.uniform_bits))
		else $error("stalled result changed");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.uniform_bits <= 32'h3F800000
			&& out_ch.uniform_bits >= 32'h2F000000)
		else $error("uniform out of range");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.random_word == 32'd0 |-> out_ch.uniform_bits == 32'h2F000000)
		else $error("zero word mapping");
endmodule

>>> rtl/core/phx_round_cell.sv
// One Philox round cell: multiplies in one stage, mixes in the next.
module phx_round_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_in,
	input  phx_pkg::blk_t      blk_in,
	output logic               vld_out,
	output phx_pkg::blk_t      blk_out
);
	logic [63:0]   p0_s1, p1_s1;
	phx_pkg::blk_t blk_s1;
	logic          vld_s1;
	phx_pkg::blk_t nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_out <= 1'b0;
		end else if (en) begin
			vld_s1  <= vld_in;
			vld_out <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1   <= 64'(phx_pkg::MUL0) * 64'(blk_in.c0);
			p1_s1   <= 64'(phx_pkg::MUL1) * 64'(blk_in.c2);
			blk_s1  <= blk_in;
			blk_out <= nxt;
		end
	end

	always_comb begin
		nxt.c0 = p1_s1[63:32] ^ blk_s1.c1 ^ blk_s1.k0;
		nxt.c1 = p1_s1[31:0];
		nxt.c2 = p0_s1[63:32] ^ blk_s1.c3 ^ blk_s1.k1;
		nxt.c3 = p0_s1[31:0];
		nxt.k0 = blk_s1.k0 + phx_pkg::WEYL0;
		nxt.k1 = blk_s1.k1 + phx_pkg::WEYL1;
	end
endmodule

>>> rtl/core/phx_uniform_cell.sv
// Word to uniform single conversion, two stages.
module phx_uniform_cell (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld_in,
	input  logic [31:0] word_in,
	output logic        vld_out,
	output logic [31:0] word_out,
	output logic [31:0] bits_out
);
	logic [32:0] r_c, r_s1;
	logic [31:0] w_s1;
	logic        vld_s1;
	logic [5:0]  n;
	logic [31:0] msk, m_sh;
	logic        rnd;
	logic [33:0] y;
	logic [5:0]  ln;
	logic [7:0]  ex;
	logic [22:0] fr;
	logic [33:0] yt;
	logic [9:0]  rb;

	// round word to 24 significant bits
	always_comb begin
		n = 6'd0;
		for (int i = 0; i < 32; i++)
			if (word_in[i]) n = 6'(i + 1);
		r_c = {1'b0, word_in};
		msk = '0;
		m_sh = '0;
		rnd = 1'b0;
		if (n > 6'd24) begin
			msk = (32'd1 << (n - 6'd24)) - 32'd1;
			m_sh = word_in & ~msk;
			// half bit at n-25, sticky below, lsb at n-24
			rnd = word_in[5'(n - 6'd25)] &&
				(((word_in & (msk >> 1)) != 32'd0) || word_in[5'(n - 6'd24)]);
			r_c = {1'b0, m_sh} + (rnd ? (33'd1 << (n - 6'd24)) : 33'd0);
		end
	end

	// y = 2r+1 has at most 34 bits; round to 24 and build the float
	always_comb begin
		y = {r_s1, 1'b1};
		ln = 6'd0;
		for (int i = 0; i < 34; i++)
			if (y[i]) ln = 6'(i + 1);
		yt = y;
		rb = '0;
		if (ln > 6'd24) begin
			yt = y >> (ln - 6'd24);
			rb = 10'(y << (6'd34 - (ln - 6'd24)) >> 24);
			// rb holds dropped bits top-aligned in 10 bits
			if (rb[9] && ((rb[8:0] != 9'd0) || yt[0]))
				yt = yt + 34'd1;
		end
		ex = 8'(ln) + 8'd93;
		if (yt[24]) begin
			ex = ex + 8'd1;
			fr = '0;
		end else if (ln > 6'd24) begin
			fr = yt[22:0];
		end else begin
			fr = 23'(y << (6'd24 - ln));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_out <= 1'b0;
		end else if (en) begin
			vld_s1  <= vld_in;
			vld_out <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1     <= (word_in == 32'd0) ? 33'd0 : r_c;
			w_s1     <= word_in;
			word_out <= w_s1;
			bits_out <= {1'b0, ex, fr};
		end
	end
endmodule
